[rtl/mptd_pkg.sv]
package mptd_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_GRID_WIDTH    = 3'd0,
      CSR_GRID_HEIGHT   = 3'd1,
      CSR_SCALE_COUNT   = 3'd2,
      CSR_RATIO_COUNT   = 3'd3,
      CSR_SEARCH_RADIUS = 3'd4
   } csr_index_type;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 6;
   localparam int GRID_CFG_W   = 6;
   localparam int COUNT_CFG_W  = 3;

   localparam int SCORE_W      = 24;
   localparam int SUM_W        = 32;
   localparam int FRAME_W      = 16;
   localparam int EPOCH_W      = 24;
   localparam int POS_XY_W     = 5;
   localparam int POS_SR_W     = 2;

   localparam int DEF_MAX_SCALES = 4;
   localparam int DEF_MAX_RATIOS = 4;
   localparam int DEF_GRID_MAX   = 32;
   localparam int DEF_RADIUS_MAX = 4;

   localparam logic [GRID_CFG_W-1:0]  RST_GRID_WIDTH    = 6'd32;
   localparam logic [GRID_CFG_W-1:0]  RST_GRID_HEIGHT   = 6'd32;
   localparam logic [COUNT_CFG_W-1:0] RST_SCALE_COUNT   = 3'd4;
   localparam logic [COUNT_CFG_W-1:0] RST_RATIO_COUNT   = 3'd4;
   localparam logic [COUNT_CFG_W-1:0] RST_SEARCH_RADIUS = 3'd2;

   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [FRAME_W-1:0]      FRAME_SAT = {FRAME_W{1'b1}};

   typedef enum logic {
      KIND_CELL    = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

endpackage

[rtl/max_path_trellis_dp.sv]
// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// request  | req_valid/req_ready, req_cell_score, req_last_cell | in
// response | rsp_valid/rsp_ready, rsp_* result fields      | out
// csr      | csr_write_en, csr_index, csr_wdata            | in
//
// One cell at a time. Each cell reads every entry of its clipped window from the
// sums memory (scales x ratios x rows x columns of the window, up to 9 x 81),
// then does a read-modify-write of its own entry, then hands off its results.
// First-frame cells skip the window scan.
// Each memory entry holds the committed and the working sum plus a frame
// tag; a frame end only bumps the tag counter, so no copy or clearing pass.
// Synchronous reset clears control state; memory contents are left as is.
// A stalled response holds the block; no new item is taken until it drains.
module max_path_trellis_dp
   import mptd_pkg::*;
#(
   parameter int MAX_SCALES = DEF_MAX_SCALES,
   parameter int MAX_RATIOS = DEF_MAX_RATIOS,
   parameter int GRID_MAX   = DEF_GRID_MAX,
   parameter int RADIUS_MAX = DEF_RADIUS_MAX
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SCORE_W-1:0] req_cell_score,
   input  logic                      req_last_cell,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_result_kind,
   output logic signed [SUM_W-1:0]   rsp_path_sum,
   output logic [POS_XY_W-1:0]       rsp_pos_x,
   output logic [POS_XY_W-1:0]       rsp_pos_y,
   output logic [POS_SR_W-1:0]       rsp_pos_scale,
   output logic [POS_SR_W-1:0]       rsp_pos_ratio,
   output logic [FRAME_W-1:0]        rsp_frame_index,
   output logic                      rsp_has_link,
   output logic                      rsp_last_result,
   input  logic                      csr_write_en,
   input  logic [CSR_ADDR_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SW    = (MAX_SCALES > 1) ? $clog2(MAX_SCALES) : 1;
   localparam int RW    = (MAX_RATIOS > 1) ? $clog2(MAX_RATIOS) : 1;
   localparam int XW    = $clog2(GRID_MAX);
   localparam int DEPTH = MAX_SCALES * MAX_RATIOS * GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = EPOCH_W + 2 * SUM_W;
   localparam logic [15:0] GRID_MAX_16   = 16'(GRID_MAX);
   localparam logic [15:0] SCALES_16     = 16'(MAX_SCALES);
   localparam logic [15:0] RATIOS_16     = 16'(MAX_RATIOS);
   localparam logic [15:0] RADIUS_MAX_16 = 16'(RADIUS_MAX);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_LAST, ST_OWN, ST_EMIT_CELL, ST_EMIT_SUM
   } state_type;

   // configuration
   logic [GRID_CFG_W-1:0]  grid_width_ff, grid_height_ff;
   logic [COUNT_CFG_W-1:0] scale_count_ff, ratio_count_ff, search_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff    <= RST_GRID_WIDTH;
         grid_height_ff   <= RST_GRID_HEIGHT;
         scale_count_ff   <= RST_SCALE_COUNT;
         ratio_count_ff   <= RST_RATIO_COUNT;
         search_radius_ff <= RST_SEARCH_RADIUS;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:    grid_width_ff    <= csr_wdata;
            CSR_GRID_HEIGHT:   grid_height_ff   <= csr_wdata;
            CSR_SCALE_COUNT:   scale_count_ff   <= csr_wdata[COUNT_CFG_W-1:0];
            CSR_RATIO_COUNT:   ratio_count_ff   <= csr_wdata[COUNT_CFG_W-1:0];
            CSR_SEARCH_RADIUS: search_radius_ff <= csr_wdata[COUNT_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [15:0] gw, gh, sc, rc, rad;
   always_comb begin
      gw  = 16'(grid_width_ff);
      gh  = 16'(grid_height_ff);
      sc  = 16'(scale_count_ff);
      rc  = 16'(ratio_count_ff);
      rad = 16'(search_radius_ff);
      gw  = (gw == 16'd0) ? 16'd1 : ((gw > GRID_MAX_16) ? GRID_MAX_16 : gw);
      gh  = (gh == 16'd0) ? 16'd1 : ((gh > GRID_MAX_16) ? GRID_MAX_16 : gh);
      sc  = (sc == 16'd0) ? 16'd1 : ((sc > SCALES_16) ? SCALES_16 : sc);
      rc  = (rc == 16'd0) ? 16'd1 : ((rc > RATIOS_16) ? RATIOS_16 : rc);
      rad = (rad == 16'd0) ? 16'd1 : ((rad > RADIUS_MAX_16) ? RADIUS_MAX_16 : rad);
   end

   // state registers
   state_type state_ff;
   logic [SW-1:0] pos_s_ff;
   logic [RW-1:0] pos_r_ff;
   logic [XW-1:0] pos_y_ff, pos_x_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   logic signed [SUM_W-1:0] best_ff;
   logic [SW-1:0] bl_s_ff;
   logic [RW-1:0] bl_r_ff;
   logic [XW-1:0] bl_y_ff, bl_x_ff;
   logic [FRAME_W-1:0] bl_f_ff;
   logic bl_valid_ff;

   // per-item registers
   logic signed [SCORE_W-1:0] score_ff;
   logic last_ff;
   logic [SW-1:0] s1_ff, s2_ff, cs_ff;
   logic [RW-1:0] r1_ff, r2_ff, cr_ff;
   logic [XW-1:0] y1_ff, y2_ff, cy_ff, x1_ff, x2_ff, cx_ff;
   logic [SW-1:0] ps_ff, ts_ff;
   logic [RW-1:0] pr_ff, tr_ff;
   logic [XW-1:0] py_ff, px_ff, ty_ff, tx_ff;
   logic v1_ff;
   logic signed [SUM_W-1:0] top_ff;

   // output registers
   logic rsp_valid_ff, kind_ff, link_ff, lastres_ff;
   logic signed [SUM_W-1:0] osum_ff;
   logic [POS_XY_W-1:0] ox_ff, oy_ff;
   logic [POS_SR_W-1:0] os_ff, or_ff;
   logic [FRAME_W-1:0] of_ff;

   // sums memory
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr, own_addr, scan_addr;
   logic          wr_en;
   logic [EW-1:0] wr_data;

   always_comb begin
      scan_addr = ((AW'(cs_ff) * AW'(MAX_RATIOS) + AW'(cr_ff)) * AW'(GRID_MAX)
                   + AW'(cy_ff)) * AW'(GRID_MAX) + AW'(cx_ff);
      own_addr  = ((AW'(pos_s_ff) * AW'(MAX_RATIOS) + AW'(pos_r_ff)) * AW'(GRID_MAX)
                   + AW'(pos_y_ff)) * AW'(GRID_MAX) + AW'(pos_x_ff);
      rd_addr   = (state_ff == ST_SCAN) ? scan_addr : own_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[own_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // committed sum of the entry just read: working value counts once its frame ended
   logic signed [SUM_W-1:0] eff_prev;
   assign eff_prev = (rd_data_ff[EW-1 -: EPOCH_W] == epoch_ff)
                     ? rd_data_ff[SUM_W-1:0] : rd_data_ff[2*SUM_W-1 -: SUM_W];

   // window bounds of the accepted cell
   logic [15:0] ps16, pr16, py16, px16;
   logic [15:0] s1, s2, r1, r2, y1, y2, x1, x2;
   logic        win_empty;
   always_comb begin
      ps16 = 16'(pos_s_ff);
      pr16 = 16'(pos_r_ff);
      py16 = 16'(pos_y_ff);
      px16 = 16'(pos_x_ff);
      s1 = (ps16 > 16'd0) ? ps16 - 16'd1 : 16'd0;
      s2 = (ps16 + 16'd1 < sc - 16'd1) ? ps16 + 16'd1 : sc - 16'd1;
      r1 = (pr16 > 16'd0) ? pr16 - 16'd1 : 16'd0;
      r2 = (pr16 + 16'd1 < rc - 16'd1) ? pr16 + 16'd1 : rc - 16'd1;
      y1 = (py16 > rad) ? py16 - rad : 16'd0;
      y2 = (py16 + rad < gh - 16'd1) ? py16 + rad : gh - 16'd1;
      x1 = (px16 > rad) ? px16 - rad : 16'd0;
      x2 = (px16 + rad < gw - 16'd1) ? px16 + rad : gw - 16'd1;
      win_empty = (s1 > s2) || (r1 > r2) || (y1 > y2) || (x1 > x2);
   end

   // cell sum
   logic signed [SUM_W:0]   wide_sum;
   logic signed [SUM_W-1:0] cell_sum;
   logic                    link;
   always_comb begin
      link     = (frame_ff != '0) && (top_ff > 0);
      wide_sum = {top_ff[SUM_W-1], top_ff} + (SUM_W+1)'(score_ff);
      if (!link) begin
         cell_sum = SUM_W'(score_ff);
      end else if (wide_sum > (SUM_W+1)'(SUM_MAX)) begin
         cell_sum = SUM_MAX;
      end else if (wide_sum < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
         cell_sum = SUM_MIN;
      end else begin
         cell_sum = wide_sum[SUM_W-1:0];
      end
      wr_en   = (state_ff == ST_OWN);
      wr_data = {epoch_ff, cell_sum, eff_prev};
   end

   // next cell position
   logic        col_wrap, row_wrap, rat_wrap, scl_wrap;
   always_comb begin
      col_wrap = 16'(pos_x_ff) + 16'd1 >= gw;
      row_wrap = 16'(pos_y_ff) + 16'd1 >= gh;
      rat_wrap = 16'(pos_r_ff) + 16'd1 >= rc;
      scl_wrap = 16'(pos_s_ff) + 16'd1 >= sc;
   end

   logic [15:0] bx16, by16, bs16, br16, lx16, ly16, ls16, lr16;
   always_comb begin
      bx16 = 16'(bl_x_ff);
      by16 = 16'(bl_y_ff);
      bs16 = 16'(bl_s_ff);
      br16 = 16'(bl_r_ff);
      lx16 = link ? 16'(tx_ff) : 16'd0;
      ly16 = link ? 16'(ty_ff) : 16'd0;
      ls16 = link ? 16'(ts_ff) : 16'd0;
      lr16 = link ? 16'(tr_ff) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_s_ff     <= '0;
         pos_r_ff     <= '0;
         pos_y_ff     <= '0;
         pos_x_ff     <= '0;
         frame_ff     <= '0;
         epoch_ff     <= '0;
         best_ff      <= SUM_MIN;
         bl_s_ff      <= '0;
         bl_r_ff      <= '0;
         bl_y_ff      <= '0;
         bl_x_ff      <= '0;
         bl_f_ff      <= '0;
         bl_valid_ff  <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= 1'b0;
         if (v1_ff && (eff_prev > top_ff)) begin
            top_ff <= eff_prev;
            ts_ff  <= ps_ff;
            tr_ff  <= pr_ff;
            ty_ff  <= py_ff;
            tx_ff  <= px_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  score_ff <= req_cell_score;
                  last_ff  <= req_last_cell;
                  top_ff   <= SUM_MIN;
                  s1_ff <= SW'(s1);
                  s2_ff <= SW'(s2);
                  r1_ff <= RW'(r1);
                  r2_ff <= RW'(r2);
                  y1_ff <= XW'(y1);
                  y2_ff <= XW'(y2);
                  x1_ff <= XW'(x1);
                  x2_ff <= XW'(x2);
                  cs_ff <= SW'(s1);
                  cr_ff <= RW'(r1);
                  cy_ff <= XW'(y1);
                  cx_ff <= XW'(x1);
                  state_ff <= ((frame_ff != '0) && !win_empty) ? ST_SCAN : ST_LAST;
               end
            end
            ST_SCAN: begin
               v1_ff <= 1'b1;
               ps_ff <= cs_ff;
               pr_ff <= cr_ff;
               py_ff <= cy_ff;
               px_ff <= cx_ff;
               if (cx_ff != x2_ff) begin
                  cx_ff <= cx_ff + 1'b1;
               end else begin
                  cx_ff <= x1_ff;
                  if (cy_ff != y2_ff) begin
                     cy_ff <= cy_ff + 1'b1;
                  end else begin
                     cy_ff <= y1_ff;
                     if (cr_ff != r2_ff) begin
                        cr_ff <= cr_ff + 1'b1;
                     end else begin
                        cr_ff <= r1_ff;
                        if (cs_ff != s2_ff) begin
                           cs_ff <= cs_ff + 1'b1;
                        end else begin
                           state_ff <= ST_LAST;
                        end
                     end
                  end
               end
            end
            ST_LAST: begin
               // own-entry read issued here; last window compare lands too
               state_ff <= ST_OWN;
            end
            ST_OWN: begin
               if ((frame_ff != '0) && (cell_sum > best_ff)) begin
                  best_ff     <= cell_sum;
                  bl_s_ff     <= pos_s_ff;
                  bl_r_ff     <= pos_r_ff;
                  bl_y_ff     <= pos_y_ff;
                  bl_x_ff     <= pos_x_ff;
                  bl_f_ff     <= frame_ff;
                  bl_valid_ff <= 1'b1;
               end
               rsp_valid_ff <= 1'b1;
               kind_ff      <= KIND_CELL;
               osum_ff      <= cell_sum;
               ox_ff        <= lx16[POS_XY_W-1:0];
               oy_ff        <= ly16[POS_XY_W-1:0];
               os_ff        <= ls16[POS_SR_W-1:0];
               or_ff        <= lr16[POS_SR_W-1:0];
               of_ff        <= frame_ff;
               link_ff      <= link;
               lastres_ff   <= !last_ff;
               if (col_wrap) begin
                  pos_x_ff <= '0;
                  if (row_wrap) begin
                     pos_y_ff <= '0;
                     if (rat_wrap) begin
                        pos_r_ff <= '0;
                        if (scl_wrap) begin
                           pos_s_ff <= '0;
                           epoch_ff <= epoch_ff + 1'b1;
                           if (frame_ff != FRAME_SAT) begin
                              frame_ff <= frame_ff + 1'b1;
                           end
                        end else begin
                           pos_s_ff <= pos_s_ff + 1'b1;
                        end
                     end else begin
                        pos_r_ff <= pos_r_ff + 1'b1;
                     end
                  end else begin
                     pos_y_ff <= pos_y_ff + 1'b1;
                  end
               end else begin
                  pos_x_ff <= pos_x_ff + 1'b1;
               end
               state_ff <= ST_EMIT_CELL;
            end
            ST_EMIT_CELL: begin
               if (rsp_ready) begin
                  if (last_ff) begin
                     kind_ff     <= KIND_SUMMARY;
                     osum_ff     <= best_ff;
                     ox_ff       <= bx16[POS_XY_W-1:0];
                     oy_ff       <= by16[POS_XY_W-1:0];
                     os_ff       <= bs16[POS_SR_W-1:0];
                     or_ff       <= br16[POS_SR_W-1:0];
                     of_ff       <= bl_f_ff;
                     link_ff     <= bl_valid_ff;
                     lastres_ff  <= 1'b1;
                     // volume restart
                     pos_s_ff    <= '0;
                     pos_r_ff    <= '0;
                     pos_y_ff    <= '0;
                     pos_x_ff    <= '0;
                     frame_ff    <= '0;
                     best_ff     <= SUM_MIN;
                     bl_s_ff     <= '0;
                     bl_r_ff     <= '0;
                     bl_y_ff     <= '0;
                     bl_x_ff     <= '0;
                     bl_f_ff     <= '0;
                     bl_valid_ff <= 1'b0;
                     state_ff    <= ST_EMIT_SUM;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            ST_EMIT_SUM: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_path_sum    = osum_ff;
   assign rsp_pos_x       = ox_ff;
   assign rsp_pos_y       = oy_ff;
   assign rsp_pos_scale   = os_ff;
   assign rsp_pos_ratio   = or_ff;
   assign rsp_frame_index = of_ff;
   assign rsp_has_link    = link_ff;
   assign rsp_last_result = lastres_ff;

endmodule

[bench/max_path_trellis_dp_tb.sv]
module max_path_trellis_dp_tb;
   import mptd_pkg::*;

   localparam int NCELLS       = DEF_MAX_SCALES * DEF_MAX_RATIOS * DEF_GRID_MAX * DEF_GRID_MAX;
   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      last;
   } cell_item_t;

   typedef struct {
      result_kind_type          kind;
      logic signed [SUM_W-1:0]  sum;
      logic [POS_XY_W-1:0]      x;
      logic [POS_XY_W-1:0]      y;
      logic [POS_SR_W-1:0]      s;
      logic [POS_SR_W-1:0]      r;
      logic [FRAME_W-1:0]       frame;
      logic                     link;
      logic                     last;
   } path_result_t;

   logic                      clock, reset;
   logic                      req_valid, req_ready, req_last_cell;
   logic signed [SCORE_W-1:0] req_cell_score;
   logic                      rsp_valid, rsp_ready, rsp_result_kind;
   logic signed [SUM_W-1:0]   rsp_path_sum;
   logic [POS_XY_W-1:0]       rsp_pos_x, rsp_pos_y;
   logic [POS_SR_W-1:0]       rsp_pos_scale, rsp_pos_ratio;
   logic [FRAME_W-1:0]        rsp_frame_index;
   logic                      rsp_has_link, rsp_last_result;
   logic                      csr_write_en;
   logic [CSR_ADDR_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   max_path_trellis_dp DUT (.*);

   cell_item_t   pending_cells[$];
   path_result_t expected_paths[$];

   // predictor state
   logic [CSR_DATA_W-1:0]    cfg_raw[5];
   logic signed [SUM_W-1:0]  prev_sums[NCELLS];
   logic signed [SUM_W-1:0]  cur_sums[NCELLS];
   int                       at_x, at_y, at_r, at_s;
   int                       frame_no;
   logic signed [SUM_W-1:0]  best_sum;
   int                       best_x, best_y, best_s, best_r, best_f;
   bit                       best_ok;

   int  mismatches;
   int  idle_cycles;
   bit  req_took, rsp_took;
   int  req_gap, rsp_stall;
   bit  req_calm, rsp_calm;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int cfg_val(csr_index_type idx, int hi);
      return clampi(int'(cfg_raw[idx]), 1, hi);
   endfunction

   function automatic int sum_addr(int s, int r, int y, int x);
      return ((s * DEF_MAX_RATIOS + r) * DEF_GRID_MAX + y) * DEF_GRID_MAX + x;
   endfunction

   function automatic void restart_volume();
      at_x = 0; at_y = 0; at_r = 0; at_s = 0;
      frame_no = 0;
      best_sum = SUM_MIN;
      best_x = 0; best_y = 0; best_s = 0; best_r = 0; best_f = 0;
      best_ok = 0;
   endfunction

   function automatic void predict_cell(logic signed [SCORE_W-1:0] score, logic last);
      int gw, gh, sc, rc, rad;
      int s, r, y, x;
      int s_lo, s_hi, r_lo, r_hi, y_lo, y_hi, x_lo, x_hi;
      logic signed [SUM_W-1:0] top, sum;
      longint wide;
      bit found, link;
      path_result_t res;
      gw  = cfg_val(CSR_GRID_WIDTH, DEF_GRID_MAX);
      gh  = cfg_val(CSR_GRID_HEIGHT, DEF_GRID_MAX);
      sc  = cfg_val(CSR_SCALE_COUNT, DEF_MAX_SCALES);
      rc  = cfg_val(CSR_RATIO_COUNT, DEF_MAX_RATIOS);
      rad = cfg_val(CSR_SEARCH_RADIUS, DEF_RADIUS_MAX);
      sum = score;
      link = 0;
      res.x = 0; res.y = 0; res.s = 0; res.r = 0;
      if (frame_no > 0) begin
         top = SUM_MIN;
         found = 0;
         s_lo = at_s > 0 ? at_s - 1 : 0;
         s_hi = at_s + 1 < sc - 1 ? at_s + 1 : sc - 1;
         r_lo = at_r > 0 ? at_r - 1 : 0;
         r_hi = at_r + 1 < rc - 1 ? at_r + 1 : rc - 1;
         y_lo = at_y > rad ? at_y - rad : 0;
         y_hi = at_y + rad < gh - 1 ? at_y + rad : gh - 1;
         x_lo = at_x > rad ? at_x - rad : 0;
         x_hi = at_x + rad < gw - 1 ? at_x + rad : gw - 1;
         for (s = s_lo; s <= s_hi; s++)
            for (r = r_lo; r <= r_hi; r++)
               for (y = y_lo; y <= y_hi; y++)
                  for (x = x_lo; x <= x_hi; x++)
                     if (prev_sums[sum_addr(s, r, y, x)] > top) begin
                        top = prev_sums[sum_addr(s, r, y, x)];
                        found = 1;
                        res.x = POS_XY_W'(x); res.y = POS_XY_W'(y);
                        res.s = POS_SR_W'(s); res.r = POS_SR_W'(r);
                     end
         if (found && top > 0) begin
            wide = longint'(top) + longint'(score);
            sum = wide > longint'(SUM_MAX) ? SUM_MAX :
                  wide < longint'(SUM_MIN) ? SUM_MIN : SUM_W'(wide);
            link = 1;
         end else begin
            res.x = 0; res.y = 0; res.s = 0; res.r = 0;
         end
      end
      cur_sums[sum_addr(at_s, at_r, at_y, at_x)] = sum;
      if (frame_no > 0 && sum > best_sum) begin
         best_sum = sum;
         best_x = at_x; best_y = at_y; best_s = at_s; best_r = at_r; best_f = frame_no;
         best_ok = 1;
      end
      res.kind = KIND_CELL; res.sum = sum; res.frame = FRAME_W'(frame_no);
      res.link = link; res.last = !last;
      expected_paths.push_back(res);

      at_x++;
      if (at_x >= gw) begin
         at_x = 0; at_y++;
         if (at_y >= gh) begin
            at_y = 0; at_r++;
            if (at_r >= rc) begin
               at_r = 0; at_s++;
               if (at_s >= sc) begin
                  at_s = 0;
                  prev_sums = cur_sums;
                  if (frame_no < int'(FRAME_SAT)) frame_no++;
               end
            end
         end
      end

      if (last) begin
         res.kind = KIND_SUMMARY; res.sum = best_sum;
         res.x = POS_XY_W'(best_x); res.y = POS_XY_W'(best_y);
         res.s = POS_SR_W'(best_s); res.r = POS_SR_W'(best_r);
         res.frame = FRAME_W'(best_f); res.link = best_ok; res.last = 1;
         expected_paths.push_back(res);
         restart_volume();
      end
   endfunction

   // sampling, prediction, checking and watchdog
   always @(posedge clock) begin
      path_result_t want;
      req_took <= 0;
      rsp_took <= 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_took <= 1;
            predict_cell(req_cell_score, req_last_cell);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_took <= 1;
            if (expected_paths.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d sum %0d",
                           rsp_result_kind, rsp_path_sum);
            end else begin
               want = expected_paths.pop_front();
               if (rsp_result_kind !== want.kind || rsp_path_sum !== want.sum ||
                   rsp_pos_x !== want.x || rsp_pos_y !== want.y ||
                   rsp_pos_scale !== want.s || rsp_pos_ratio !== want.r ||
                   rsp_frame_index !== want.frame || rsp_has_link !== want.link ||
                   rsp_last_result !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp kind %0d sum %0d x %0d y %0d s %0d r %0d",
                               " f %0d link %0d last %0d | got kind %0d sum %0d x %0d",
                               " y %0d s %0d r %0d f %0d link %0d last %0d"},
                        want.kind, want.sum, want.x, want.y, want.s, want.r, want.frame,
                        want.link, want.last, rsp_result_kind, rsp_path_sum, rsp_pos_x,
                        rsp_pos_y, rsp_pos_scale, rsp_pos_ratio, rsp_frame_index,
                        rsp_has_link, rsp_last_result);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
            idle_cycles = 0;
         else if (req_valid || pending_cells.size() != 0 || expected_paths.size() != 0)
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      cell_item_t it;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_took) begin
         if (req_took) begin
            if ($urandom_range(0, 99) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 19);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 0;
         end else if (pending_cells.size() != 0) begin
            it = pending_cells.pop_front();
            req_cell_score <= it.score;
            req_last_cell  <= it.last;
            req_valid      <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_took) begin
         if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
         rsp_stall = rsp_calm ? 0 : $urandom_range(0, 19);
      end
      if (reset || rsp_stall == 0) begin
         rsp_ready <= 1;
      end else begin
         rsp_stall--;
         rsp_ready <= 0;
      end
   end

   task automatic write_csr(csr_index_type idx, int val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_W'(val);
      cfg_raw[idx] = CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic set_shape(int gw, int gh, int sc, int rc, int rad);
      write_csr(CSR_GRID_WIDTH, gw);
      write_csr(CSR_GRID_HEIGHT, gh);
      write_csr(CSR_SCALE_COUNT, sc);
      write_csr(CSR_RATIO_COUNT, rc);
      write_csr(CSR_SEARCH_RADIUS, rad);
   endtask

   task automatic drain();
      wait (pending_cells.size() == 0 && expected_paths.size() == 0 && !req_valid);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(SCORE_W-1){1'b1}}};
         1:       return {1'b1, {(SCORE_W-1){1'b0}}};
         2, 3, 4: return SCORE_W'($urandom_range(0, 65535));
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   // one volume under the current shape; cut < 0 runs whole frames
   task automatic queue_volume(int frames, int cut, output int n);
      int per_frame;
      cell_item_t it;
      per_frame = cfg_val(CSR_GRID_WIDTH, DEF_GRID_MAX) *
                  cfg_val(CSR_GRID_HEIGHT, DEF_GRID_MAX) *
                  cfg_val(CSR_SCALE_COUNT, DEF_MAX_SCALES) *
                  cfg_val(CSR_RATIO_COUNT, DEF_MAX_RATIOS);
      n = (cut < 0) ? frames * per_frame : (frames - 1) * per_frame + cut + 1;
      for (int i = 0; i < n; i++) begin
         it.score = pick_score();
         it.last  = (i == n - 1);
         pending_cells.push_back(it);
      end
   endtask

   task automatic queue_cell(logic signed [SCORE_W-1:0] score, logic last);
      cell_item_t it;
      it.score = score;
      it.last  = last;
      pending_cells.push_back(it);
   endtask

   initial begin
      int total, n, gw, gh, sc, rc, rad;
      reset = 1;
      req_valid = 0; req_cell_score = 0; req_last_cell = 0;
      rsp_ready = 1;
      csr_write_en = 0; csr_index = CSR_GRID_WIDTH; csr_wdata = 0;
      mismatches = 0; idle_cycles = 0;
      req_took = 0; rsp_took = 0; req_gap = 0; rsp_stall = 0;
      req_calm = 0; rsp_calm = 0;
      cfg_raw[CSR_GRID_WIDTH]    = RST_GRID_WIDTH;
      cfg_raw[CSR_GRID_HEIGHT]   = RST_GRID_HEIGHT;
      cfg_raw[CSR_SCALE_COUNT]   = CSR_DATA_W'(RST_SCALE_COUNT);
      cfg_raw[CSR_RATIO_COUNT]   = CSR_DATA_W'(RST_RATIO_COUNT);
      cfg_raw[CSR_SEARCH_RADIUS] = CSR_DATA_W'(RST_SEARCH_RADIUS);
      foreach (prev_sums[i]) begin
         prev_sums[i] = 0;
         cur_sums[i] = 0;
      end
      restart_volume();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: 2x2 grid, one plane
      set_shape(2, 2, 1, 1, 1);
      queue_cell(0, 1);                              // summary with no best yet
      queue_cell({1'b0, {(SCORE_W-1){1'b1}}}, 0);    // frame 0 extremes
      queue_cell({1'b1, {(SCORE_W-1){1'b0}}}, 0);
      queue_cell(0, 0);
      queue_cell(100, 0);
      queue_cell(-5, 0);                             // frame 1 links to the max
      queue_cell({1'b1, {(SCORE_W-1){1'b0}}}, 0);
      queue_cell(7, 0);
      queue_cell({1'b0, {(SCORE_W-1){1'b1}}}, 0);
      queue_cell(1, 0);
      queue_cell(2, 1);                              // mark mid-frame
      // all-negative frame 0 so frame 1 restarts without link
      queue_cell(-1, 0); queue_cell(-2, 0); queue_cell(-3, 0); queue_cell(-4, 0);
      queue_cell(-9, 0); queue_cell(-8, 0); queue_cell(-7, 0); queue_cell(-6, 1);
      drain();

      // out-of-range register values clamp
      set_shape(63, 0, 0, 7, 7);
      queue_volume(2, -1, n);
      drain();
      set_shape(1, 32, 1, 1, 4);
      queue_volume(2, -1, n);
      drain();
      set_shape(2, 2, 4, 4, 1);
      queue_volume(2, -1, n);
      drain();

      total = 0;
      while (total < RANDOM_ITEMS) begin
         gw = $urandom_range(1, 6);
         gh = $urandom_range(1, 6);
         sc = $urandom_range(1, 4);
         rc = $urandom_range(1, 4);
         rad = $urandom_range(1, 4);
         while (gw * gh * sc * rc > 48) begin
            if (gw > 1) gw--;
            if (gh > 1) gh--;
            if (sc > 1) sc--;
         end
         set_shape(gw, gh, sc, rc, rad);
         for (int v = $urandom_range(1, 2); v > 0; v--) begin
            if ($urandom_range(0, 3) == 0)
               queue_volume($urandom_range(1, 4),
                            $urandom_range(0, gw * gh * sc * rc - 1), n);
            else
               queue_volume($urandom_range(1, 4), -1, n);
            total += n;
         end
         drain();
      end

      repeat (1000) @(posedge clock);
      if (mismatches == 0 && expected_paths.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
